// ----- design/lgm_pkg.sv -----
// Shared constants, types and helper functions of the greedy LZ match finder.
`timescale 1ns / 1ps
`default_nettype none
package lgm_pkg;

	localparam int WINDOW       = 4096;
	localparam int HASH_ENTRIES = 512;
	localparam int RING_ENTRIES = 4160;
	localparam int POS_W        = 32;
	localparam int LEN_W        = 7;
	localparam int DIST_W       = 13;
	localparam int RING_W       = 13;
	localparam int HASH_W       = 9;
	localparam int CHAIN_AW     = 12;
	localparam int TAG_W        = 8;
	localparam int HEAD_W       = TAG_W + POS_W;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = 2;

	localparam logic [RING_W:0]    RING_SIZE = 14'd4160;
	localparam logic [LEN_W-1:0]   MAX_MATCH = 7'd64;
	localparam logic [DIST_W-1:0]  MAX_DIST  = 13'd4096;
	localparam logic [LEN_W-1:0]   MIN_LEN   = 7'd2;
	localparam logic [HASH_W-1:0]  HASH_LAST = 9'h1FF;

	localparam logic [1:0] CFG_MIN_LENGTH   = 2'd0;
	localparam logic [1:0] CFG_MAX_LENGTH   = 2'd1;
	localparam logic [1:0] CFG_MIN_DISTANCE = 2'd2;
	localparam logic [1:0] CFG_MAX_DISTANCE = 2'd3;

	typedef struct packed {
		logic [LEN_W-1:0]  min_length;
		logic [LEN_W-1:0]  max_length;
		logic [DIST_W-1:0] min_distance;
		logic [DIST_W-1:0] max_distance;
	} cfg_t;

	// One queued item: a byte and whether it closes the block.
	typedef struct packed {
		logic       flush;
		logic [7:0] data;
	} cmd_t;

	function automatic logic [RING_W-1:0] ring_add(input logic [RING_W-1:0] base,
		input logic [LEN_W-1:0] off);
		logic [RING_W:0] s;
		s = {1'b0, base} + {7'd0, off};
		if (s >= RING_SIZE) begin
			s = s - RING_SIZE;
		end
		return s[RING_W-1:0];
	endfunction

	function automatic logic [RING_W-1:0] ring_sub(input logic [RING_W-1:0] base,
		input logic [DIST_W-1:0] d);
		logic [RING_W:0] s;
		s = {1'b0, base} - {1'b0, d};
		if (s[RING_W]) begin
			s = s + RING_SIZE;
		end
		return s[RING_W-1:0];
	endfunction

	function automatic logic [HASH_W-1:0] lgm_hash(input logic [7:0] a, input logic [7:0] b,
		input logic [7:0] c, input logic three);
		logic [7:0] x1;
		logic [7:0] x2;
		logic [HASH_W-1:0] h;
		x1 = a ^ b;
		x2 = a ^ c;
		if (three) begin
			h = {1'b0, a} ^ {x1, 1'b0} ^ {x2[6:0], 2'b00} ^ {8'd0, x2[7]};
		end else begin
			h = {1'b0, a} ^ {x1[6:0], 2'b00} ^ {8'd0, x1[7]};
		end
		return h;
	endfunction

endpackage
`default_nettype wire

// ----- design/lgm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ----- design/lgm_front.sv -----
// Input side: takes items, tags block ends and queues them for the match engine.
`timescale 1ns / 1ps
`default_nettype none
module lgm_front import lgm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       block_end,
	input  wire logic       hold,
	output logic            cmd_valid,
	output cmd_t            cmd,
	input  wire logic       cmd_pop
);

	cmd_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_AW:0]   fill_q;
	logic               push;
	logic               pop;

	// Nothing is taken while the head table is being swept.
	assign in_stall  = (fill_q == (FIFO_AW+1)'(FIFO_DEPTH)) || hold;
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (fill_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = fifo_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wp_q] <= '{flush: block_end, data: data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/lgm_back.sv -----
// Match engine: keeps history and hash chains, walks chains and emits tokens.
`timescale 1ns / 1ps
`default_nettype none
module lgm_back import lgm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  cfg_t                   cfg,
	input  wire logic              cmd_valid,
	input  cmd_t                   cmd,
	output logic                   cmd_pop,
	output logic                   clearing,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   is_reference,
	output logic [7:0]             literal,
	output logic [LEN_W-1:0]       match_length,
	output logic [DIST_W-1:0]      match_distance,
	output logic                   last_token
);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_INS  = 4'd2;
	localparam logic [3:0] S_HRD1 = 4'd3;
	localparam logic [3:0] S_HRD2 = 4'd4;
	localparam logic [3:0] S_HRD3 = 4'd5;
	localparam logic [3:0] S_HRD4 = 4'd6;
	localparam logic [3:0] S_CAND = 4'd7;
	localparam logic [3:0] S_CMP  = 4'd8;
	localparam logic [3:0] S_NEXT = 4'd9;
	localparam logic [3:0] S_CHW  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;
	localparam logic [3:0] S_EMIT = 4'd12;

	logic [3:0]          state_q;
	logic [POS_W-1:0]    q_q;
	logic [RING_W-1:0]   rq_q;
	logic [LEN_W-1:0]    cnt_q;
	logic [POS_W-1:0]    ip_q;
	logic [RING_W-1:0]   rip_q;
	logic [TAG_W-1:0]    epoch_q;
	logic                flush_q;
	logic                srch_q;
	logic [HASH_W-1:0]   clr_q;
	logic [7:0]          a_q;
	logic [7:0]          b_q;
	logic [HASH_W-1:0]   h_q;
	logic [DIST_W-1:0]   d_q;
	logic [RING_W-1:0]   base_q;
	logic [LEN_W-1:0]    rdn_q;
	logic [LEN_W-1:0]    cn_q;
	logic                pend_q;
	logic [LEN_W-1:0]    best_q;
	logic [DIST_W-1:0]   bestd_q;
	logic                out_valid_q;
	logic                is_ref_q;
	logic [7:0]          lit_q;
	logic [LEN_W-1:0]    len_q;
	logic [DIST_W-1:0]   dist_q;
	logic                last_q;

	// RAM ports
	logic                hist_we;
	logic [RING_W-1:0]   hist_waddr;
	logic [RING_W-1:0]   ha_raddr;
	logic [RING_W-1:0]   hb_raddr;
	logic [7:0]          ra;
	logic [7:0]          rb;
	logic                head_we;
	logic [HASH_W-1:0]   head_waddr;
	logic [HEAD_W-1:0]   head_wdata;
	logic [HEAD_W-1:0]   hd;
	logic                chain_we;
	logic [DIST_W-1:0]   chain_wdata;
	logic [CHAIN_AW-1:0] chain_raddr;
	logic [DIST_W-1:0]   step;

	// Effective settings
	logic [LEN_W-1:0]    m_eff;
	logic [DIST_W-1:0]   maxd;
	logic [LEN_W-1:0]    ml;
	logic [LEN_W-1:0]    lim;
	logic                three;

	logic [POS_W-1:0]    q_minus_ip;
	logic [LEN_W:0]      rem;
	logic [RING_W-1:0]   rp;
	logic [HASH_W-1:0]   hash_now;
	logic                hvalid;
	logic [POS_W-1:0]    dins;
	logic [POS_W-1:0]    dsrch;
	logic [POS_W-1:0]    maxd_w;
	logic                eq;
	logic                mism;
	logic [LEN_W-1:0]    cn_nx;
	logic                stop;
	logic                issue_ok;
	logic [DIST_W:0]     dsum;
	logic                slot_free;
	logic                tok_ref;
	logic [LEN_W-1:0]    tok_len;
	logic [LEN_W-1:0]    cnt_after;
	logic [TAG_W-1:0]    epoch_nx;

	assign m_eff  = (cfg.min_length < MIN_LEN) ? MIN_LEN : cfg.min_length;
	assign maxd   = (cfg.max_distance > MAX_DIST) ? MAX_DIST : cfg.max_distance;
	assign ml     = (cfg.max_length > MAX_MATCH) ? MAX_MATCH : cfg.max_length;
	assign lim    = (ml > cnt_q) ? cnt_q : ml;
	assign three  = (m_eff > MIN_LEN);
	assign maxd_w = {19'd0, maxd};

	// Bytes left in the block from the insert position.
	assign q_minus_ip = q_q - ip_q;
	assign rem        = {1'b0, cnt_q} + {1'b0, q_minus_ip[LEN_W-1:0]};
	assign rp         = srch_q ? rq_q : rip_q;
	assign hash_now   = lgm_hash(a_q, b_q, ra, three);

	assign hvalid = (hd[HEAD_W-1:POS_W] == epoch_q);
	assign dins   = ip_q - hd[POS_W-1:0];
	assign dsrch  = q_q - hd[POS_W-1:0];

	// Streaming compare: one read issued and one byte checked per cycle.
	assign eq       = pend_q && (ra == rb);
	assign mism     = pend_q && (ra != rb);
	assign cn_nx    = cn_q + {6'd0, eq};
	assign stop     = mism || (cn_nx == lim);
	assign issue_ok = !stop && (rdn_q < lim);

	assign dsum = {1'b0, d_q} + {1'b0, step};

	assign slot_free = !out_valid_q || !out_stall;
	assign tok_ref   = (best_q >= m_eff);
	assign tok_len   = tok_ref ? best_q : 7'd1;
	assign cnt_after = cnt_q - tok_len;
	assign epoch_nx  = epoch_q + 1'b1;

	assign cmd_pop  = (state_q == S_IDLE) && cmd_valid;
	assign clearing = (state_q == S_CLR);

	assign hist_we    = cmd_pop;
	assign hist_waddr = ring_add(rq_q, cnt_q);

	always_comb begin
		ha_raddr = rq_q;
		hb_raddr = ring_add(rq_q, 7'd1);
		case (state_q)
			S_HRD1: begin
				ha_raddr = rp;
				hb_raddr = ring_add(rp, 7'd1);
			end
			S_HRD2: begin
				ha_raddr = ring_add(rp, 7'd2);
			end
			S_CMP: begin
				ha_raddr = ring_add(rq_q, rdn_q);
				hb_raddr = ring_add(base_q, rdn_q);
			end
			default: begin
				ha_raddr = rq_q;
			end
		endcase
	end

	always_comb begin
		head_we    = 1'b0;
		head_waddr = h_q;
		head_wdata = {epoch_q, ip_q};
		chain_we   = 1'b0;
		if (state_q == S_CLR) begin
			head_we    = 1'b1;
			head_waddr = clr_q;
			head_wdata = '0;
		end else if (state_q == S_HRD4 && !srch_q) begin
			head_we  = 1'b1;
			chain_we = 1'b1;
		end
	end

	assign chain_wdata = (hvalid && (dins < maxd_w)) ? dins[DIST_W-1:0] : '0;
	assign chain_raddr = q_q[CHAIN_AW-1:0] - d_q[CHAIN_AW-1:0];

	lgm_ram #(.WIDTH(8), .DEPTH(RING_ENTRIES)) u_hist_a (
		.clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(cmd.data),
		.raddr(ha_raddr), .rdata(ra)
	);

	lgm_ram #(.WIDTH(8), .DEPTH(RING_ENTRIES)) u_hist_b (
		.clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(cmd.data),
		.raddr(hb_raddr), .rdata(rb)
	);

	lgm_ram #(.WIDTH(HEAD_W), .DEPTH(HASH_ENTRIES)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(hash_now), .rdata(hd)
	);

	lgm_ram #(.WIDTH(DIST_W), .DEPTH(WINDOW)) u_chain (
		.clk(clk), .we(chain_we), .waddr(ip_q[CHAIN_AW-1:0]), .wdata(chain_wdata),
		.raddr(chain_raddr), .rdata(step)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_HRD2: begin
				a_q <= ra;
				b_q <= rb;
			end
			S_HRD3: begin
				h_q <= hash_now;
			end
			S_CAND: begin
				base_q <= ring_sub(rq_q, d_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			q_q         <= '0;
			rq_q        <= '0;
			cnt_q       <= '0;
			ip_q        <= '0;
			rip_q       <= '0;
			epoch_q     <= 8'd1;
			flush_q     <= 1'b0;
			srch_q      <= 1'b0;
			clr_q       <= '0;
			d_q         <= '0;
			rdn_q       <= '0;
			cn_q        <= '0;
			pend_q      <= 1'b0;
			best_q      <= 7'd1;
			bestd_q     <= '0;
			out_valid_q <= 1'b0;
			is_ref_q    <= 1'b0;
			lit_q       <= '0;
			len_q       <= '0;
			dist_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == HASH_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cnt_q   <= cnt_q + 1'b1;
						flush_q <= cmd.flush;
						if (cmd.flush || (cnt_q + 1'b1 == MAX_MATCH)) begin
							state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					// Catch up on positions skipped by the previous reference.
					if (ip_q != q_q) begin
						if (rem >= {1'b0, m_eff}) begin
							srch_q  <= 1'b0;
							state_q <= S_HRD1;
						end else begin
							ip_q  <= ip_q + 1'b1;
							rip_q <= ring_add(rip_q, 7'd1);
						end
					end else begin
						best_q  <= 7'd1;
						bestd_q <= '0;
						if (cnt_q >= m_eff && lim >= MIN_LEN) begin
							srch_q  <= 1'b1;
							state_q <= S_HRD1;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_HRD1: state_q <= S_HRD2;
				S_HRD2: state_q <= S_HRD3;
				S_HRD3: state_q <= S_HRD4;
				S_HRD4: begin
					if (!srch_q) begin
						ip_q    <= ip_q + 1'b1;
						rip_q   <= ring_add(rip_q, 7'd1);
						state_q <= S_INS;
					end else if (hvalid && dsrch != '0 && dsrch <= maxd_w) begin
						d_q     <= dsrch[DIST_W-1:0];
						state_q <= S_CAND;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_CAND: begin
					if (d_q >= cfg.min_distance) begin
						rdn_q   <= '0;
						cn_q    <= '0;
						pend_q  <= 1'b0;
						state_q <= S_CMP;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_CMP: begin
					if (stop) begin
						pend_q <= 1'b0;
						if (cn_nx > best_q) begin
							best_q  <= cn_nx;
							bestd_q <= d_q;
						end
						if (cn_nx > best_q && cn_nx == lim) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_NEXT;
						end
					end else begin
						cn_q   <= cn_nx;
						pend_q <= issue_ok;
						if (issue_ok) begin
							rdn_q <= rdn_q + 1'b1;
						end
					end
				end
				S_NEXT: begin
					if (d_q == maxd) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_CHW;
					end
				end
				S_CHW: begin
					if (step == '0 || dsum > {1'b0, maxd}) begin
						state_q <= S_FIN;
					end else begin
						d_q     <= dsum[DIST_W-1:0];
						state_q <= S_CAND;
					end
				end
				S_FIN: state_q <= S_EMIT;
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						is_ref_q    <= tok_ref;
						lit_q       <= tok_ref ? 8'd0 : ra;
						len_q       <= tok_len;
						dist_q      <= tok_ref ? bestd_q : '0;
						last_q      <= flush_q && (cnt_after == '0);
						if (flush_q && cnt_after == '0) begin
							q_q     <= '0;
							rq_q    <= '0;
							cnt_q   <= '0;
							ip_q    <= '0;
							rip_q   <= '0;
							flush_q <= 1'b0;
							// A wrapped block tag needs the head table swept again.
							if (epoch_nx == '0) begin
								epoch_q <= 8'd1;
								clr_q   <= '0;
								state_q <= S_CLR;
							end else begin
								epoch_q <= epoch_nx;
								state_q <= S_IDLE;
							end
						end else begin
							q_q     <= q_q + {25'd0, tok_len};
							rq_q    <= ring_add(rq_q, tok_len);
							cnt_q   <= cnt_after;
							state_q <= flush_q ? S_INS : S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign is_reference   = is_ref_q;
	assign literal        = lit_q;
	assign match_length   = len_q;
	assign match_distance = dist_q;
	assign last_token     = last_q;

endmodule
`default_nettype wire

// ----- design/lz_greedy_hash_chain_matcher_unit.sv -----
// Top level of the greedy LZ match finder: configuration registers, front and back.
`timescale 1ns / 1ps
`default_nettype none
// Bytes enter one item at a time into a four-entry queue; the match engine behind it
// stores each byte and, once 64 bytes are waiting or a block ends, decides greedy
// tokens. For a token the engine enters the positions it covers into the hash chains,
// reads the head entry, and for every chain candidate compares bytes, then emits; the
// chain walk against the history memory sets the pace, and the queue keeps taking bytes
// meanwhile until it is full. After reset, and after every 255th block, the head table
// is swept, and no item is taken during the sweep. The user must write configuration
// only while the block is idle; the block itself does not enforce this.
module lz_greedy_hash_chain_matcher_unit import lgm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        data_byte,
	input  wire logic              block_end,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   is_reference,
	output logic [7:0]             literal,
	output logic [LEN_W-1:0]       match_length,
	output logic [DIST_W-1:0]      match_distance,
	output logic                   last_token,
	input  wire logic              cfg_write,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [DIST_W-1:0] cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;
	logic clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_length   <= 7'd3;
			cfg_q.max_length   <= 7'd18;
			cfg_q.min_distance <= 13'd1;
			cfg_q.max_distance <= 13'd4096;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MIN_LENGTH:   cfg_q.min_length   <= cfg_data[LEN_W-1:0];
				CFG_MAX_LENGTH:   cfg_q.max_length   <= cfg_data[LEN_W-1:0];
				CFG_MIN_DISTANCE: cfg_q.min_distance <= cfg_data;
				CFG_MAX_DISTANCE: cfg_q.max_distance <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lgm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.block_end (block_end),
		.hold      (clearing),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	lgm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop),
		.clearing       (clearing),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.is_reference   (is_reference),
		.literal        (literal),
		.match_length   (match_length),
		.match_distance (match_distance),
		.last_token     (last_token)
	);

endmodule
`default_nettype wire
